### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

// Implication with a delay set by the n argument.
`define ASSERT_DELAY(label, clk, rst_n, n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##n (cons)) \
    else $error("assertion failed");

`endif

### rtl/m4x4acc_pkg.sv
package m4x4acc_pkg;

  // Fixed point format and matrix geometry
  localparam int unsigned FracBits = 16;
  localparam int unsigned ElemW    = 32;
  localparam int unsigned ProdW    = 2 * ElemW;
  localparam int unsigned AccW     = ProdW + 2;  // exact sum of four products
  localparam int unsigned NumCols  = 4;

  localparam logic signed [ElemW-1:0] OneQ = ElemW'(1) << FracBits;
  localparam logic [1:0] LastRow = 2'd3;

  // Item opcodes
  localparam logic OpLoad = 1'b0;
  localparam logic OpMul  = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    StIdle,
    StLoad,
    StMul,
    StDrain,
    StRound,
    StEmit
  } state_e;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic       wr_cur;  // write a row of the current matrix
    logic       wr_mul;  // write a row of the multiplier
    logic [1:0] row;     // row addressed by write, load and write back
    logic       load;    // load ring register, clear accumulator
    logic [1:0] step;    // dot product step
    logic       acc_en;  // add registered product
    logic       rnd;     // round and saturate accumulator
    logic       wb;      // write rounded result back, result shown
  } ctl_t;

  // Round to nearest (ties up), shift by FracBits, saturate to 32 bits
  function automatic logic signed [ElemW-1:0] round_sat(input logic signed [AccW-1:0] acc);
    logic [AccW:0]          half;
    logic [AccW:0]          sum;
    logic [AccW-FracBits:0] sh;
    logic                   fits;
    half = (AccW+1)'(1) << (FracBits - 1);
    sum  = {acc[AccW-1], acc} + half;
    sh   = sum[AccW:FracBits];
    fits = (&sh[AccW-FracBits:ElemW-1]) | ~(|sh[AccW-FracBits:ElemW-1]);
    if (fits) begin
      round_sat = sh[ElemW-1:0];
    end else if (sh[AccW-FracBits]) begin
      round_sat = {1'b1, {(ElemW-1){1'b0}}};
    end else begin
      round_sat = {1'b0, {(ElemW-1){1'b1}}};
    end
  endfunction

endpackage

### rtl/m4x4acc_cell.sv
// One column cell: holds one column of the current matrix and of the
// multiplier, takes row elements from its neighbor around the ring.
module m4x4acc_cell (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [1:0]                            col_i,
  input  m4x4acc_pkg::ctl_t                     ctl_i,
  input  logic signed [m4x4acc_pkg::ElemW-1:0]  elem_i,
  input  logic signed [m4x4acc_pkg::ElemW-1:0]  a_i,
  output logic signed [m4x4acc_pkg::ElemW-1:0]  a_o,
  output logic signed [m4x4acc_pkg::ElemW-1:0]  res_o
);
  import m4x4acc_pkg::*;

  logic signed [ElemW-1:0] cur_q [NumCols];
  logic signed [ElemW-1:0] mul_q [NumCols];
  logic signed [ElemW-1:0] a_q, a_d;
  logic signed [ProdW-1:0] p_q, p_d;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic signed [ElemW-1:0] res_q, res_d;
  logic [1:0]              k_idx;

  // Current matrix column, identity at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NumCols; r++) begin
        cur_q[r] <= (2'(r) == col_i) ? OneQ : '0;
      end
    end else if (ctl_i.wr_cur) begin
      cur_q[ctl_i.row] <= elem_i;
    end else if (ctl_i.wb) begin
      cur_q[ctl_i.row] <= res_q;
    end
  end

  // Multiplier column, no reset
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_mul) begin
      mul_q[ctl_i.row] <= elem_i;
    end
  end

  // Ring, product, accumulate, round
  assign k_idx = col_i + ctl_i.step;

  always_comb begin
    a_d   = ctl_i.load ? cur_q[ctl_i.row] : a_i;
    p_d   = a_q * mul_q[k_idx];
    acc_d = acc_q;
    if (ctl_i.load) begin
      acc_d = '0;
    end else if (ctl_i.acc_en) begin
      acc_d = acc_q + {{(AccW-ProdW){p_q[ProdW-1]}}, p_q};
    end
    res_d = ctl_i.rnd ? round_sat(acc_q) : res_q;
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    p_q   <= p_d;
    acc_q <= acc_d;
    res_q <= res_d;
  end

  assign a_o   = a_q;
  assign res_o = res_q;

endmodule

### rtl/m4x4acc_ctrl.sv
// Sequencer: decodes items and steps the cells through each product row.
module m4x4acc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              op_i,
  input  logic [1:0]        row_index_i,
  output logic              busy,
  output m4x4acc_pkg::ctl_t ctl_o,
  output logic              out_valid_o,
  output logic [1:0]        out_row_o,
  output logic              last_row_o
);
  import m4x4acc_pkg::*;

  state_e     state_q, state_d;
  logic [1:0] row_q, row_d;
  logic [1:0] step_q, step_d;
  logic       accept;

  assign accept = start && (state_q == StIdle);

  // Next state
  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    step_d  = step_q;
    unique case (state_q)
      StIdle: begin
        if (accept && op_i == OpMul && row_index_i == LastRow) begin
          state_d = StLoad;
          row_d   = '0;
        end
      end
      StLoad: begin
        state_d = StMul;
        step_d  = '0;
      end
      StMul: begin
        step_d = step_q + 2'd1;
        if (step_q == LastRow) begin
          state_d = StDrain;
        end
      end
      StDrain: state_d = StRound;
      StRound: state_d = StEmit;
      StEmit: begin
        if (row_q == LastRow) begin
          state_d = StIdle;
        end else begin
          row_d   = row_q + 2'd1;
          state_d = StLoad;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      row_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      step_q  <= step_d;
    end
  end

  // Outputs
  always_comb begin
    busy          = (state_q != StIdle);
    ctl_o.wr_cur  = accept && (op_i == OpLoad);
    ctl_o.wr_mul  = accept && (op_i == OpMul);
    ctl_o.row     = (state_q == StIdle) ? row_index_i : row_q;
    ctl_o.load    = (state_q == StLoad);
    ctl_o.step    = step_q;
    ctl_o.acc_en  = ((state_q == StMul) && (step_q != '0)) || (state_q == StDrain);
    ctl_o.rnd     = (state_q == StRound);
    ctl_o.wb      = (state_q == StEmit);
    out_valid_o   = (state_q == StEmit);
    out_row_o     = row_q;
    last_row_o    = (state_q == StEmit) && (row_q == LastRow);
  end

endmodule

### rtl/matrix4x4_accumulate_transform.sv
// 4x4 accumulating matrix transform, signed Q16.16.
//
// Input channel: an item is taken at a rising edge with start high and busy
// low. op_i = 0 writes row row_index_i of the current matrix; op_i = 1 writes
// that row of the multiplier. Busy stays low after such a write, except that
// writing multiplier row 3 starts current = current * multiplier.
// Output channel: out_valid_o is high for exactly one cycle per product row;
// out_row_o, res_*_o and last_row_o are valid with it. The receiver cannot
// stall; rows come out 0 to 3, last_row_o marks row 3.
// Structure: four column cells in a ring, one 32x32 multiplier each. Each row
// goes through load, four multiply steps, drain, round and show, and rows
// are shown one after another; busy stays high until row 3 is shown, and no
// new item is taken while busy. The per-cell multiplier and the four-step
// dot product set this sequence.
// Reset: current matrix becomes identity, sequencer idle. The multiplier
// must have all four rows written before the first product.
module matrix4x4_accumulate_transform (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  op_i,
  input  logic [1:0]                            row_index_i,
  input  logic signed [m4x4acc_pkg::ElemW-1:0]  elem_a_i,
  input  logic signed [m4x4acc_pkg::ElemW-1:0]  elem_b_i,
  input  logic signed [m4x4acc_pkg::ElemW-1:0]  elem_c_i,
  input  logic signed [m4x4acc_pkg::ElemW-1:0]  elem_d_i,
  output logic                                  out_valid_o,
  output logic [1:0]                            out_row_o,
  output logic signed [m4x4acc_pkg::ElemW-1:0]  res_a_o,
  output logic signed [m4x4acc_pkg::ElemW-1:0]  res_b_o,
  output logic signed [m4x4acc_pkg::ElemW-1:0]  res_c_o,
  output logic signed [m4x4acc_pkg::ElemW-1:0]  res_d_o,
  output logic                                  last_row_o
);
  import m4x4acc_pkg::*;

  ctl_t                    ctl;
  logic signed [ElemW-1:0] elem [NumCols];
  logic signed [ElemW-1:0] ring [NumCols];
  logic signed [ElemW-1:0] res  [NumCols];

  assign elem[0] = elem_a_i;
  assign elem[1] = elem_b_i;
  assign elem[2] = elem_c_i;
  assign elem[3] = elem_d_i;

  // Sequencer
  m4x4acc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .op_i        (op_i),
    .row_index_i (row_index_i),
    .busy        (busy),
    .ctl_o       (ctl),
    .out_valid_o (out_valid_o),
    .out_row_o   (out_row_o),
    .last_row_o  (last_row_o)
  );

  // Ring of column cells, each passes its row element to the one before it
  for (genvar i = 0; i < NumCols; i++) begin : g_cell
    localparam int Nxt = (i + 1) % NumCols;
    m4x4acc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .col_i  (2'(i)),
      .ctl_i  (ctl),
      .elem_i (elem[i]),
      .a_i    (ring[Nxt]),
      .a_o    (ring[i]),
      .res_o  (res[i])
    );
  end

  assign res_a_o = res[0];
  assign res_b_o = res[1];
  assign res_c_o = res[2];
  assign res_d_o = res[3];

endmodule

### rtl/m4x4acc_checker.sv
`include "assert_macros.svh"

// Port-level checks on the transform block.
module m4x4acc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       op_i,
  input logic [1:0] row_index_i,
  input logic       out_valid_o,
  input logic [1:0] out_row_o,
  input logic       last_row_o
);
  import m4x4acc_pkg::*;

  logic trigger;
  assign trigger = start && !busy && (op_i == OpMul) && (row_index_i == LastRow);

  // last flag only on a shown row 3
  `ASSERT_IMPL(a_last_row, clk_i, rst_ni, last_row_o, out_valid_o && (out_row_o == LastRow))
  // a result is shown only while busy
  `ASSERT_IMPL(a_valid_busy, clk_i, rst_ni, out_valid_o, busy)
  // product start makes the block busy
  `ASSERT_NEXT(a_trig_busy, clk_i, rst_ni, trigger, busy)
  // the trigger is followed by a shown row 0
  `ASSERT_DELAY(a_first_row, clk_i, rst_ni, 8, trigger, out_valid_o && (out_row_o == 2'd0))
  // each shown row other than row 3 is followed by the next row in order
  `ASSERT_DELAY(a_next_row, clk_i, rst_ni, 8, out_valid_o && (out_row_o != LastRow), out_valid_o && (out_row_o == $past(out_row_o, 8) + 2'd1))

endmodule

bind matrix4x4_accumulate_transform m4x4acc_checker u_m4x4acc_checker (.*);
